FILE: design/lzwd_pkg.sv
// Package for the LZSS window decoder: field types, codes and defaults.
`default_nettype none

package lzwd_pkg;

    localparam int WINDOW_BITS_DEFAULT = 12;
    localparam int LENGTH_BITS_DEFAULT = 4;
    localparam int MIN_MATCH           = 3;

    // Fixed field widths of the token and result items and of the configuration port
    localparam int COMMAND_W  = 2;
    localparam int BYTE_W     = 8;
    localparam int OFFSET_W   = 12;
    localparam int LENCODE_W  = 4;
    localparam int FILL_POS_W = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_INDEX_W = 2;

    // Token commands
    localparam logic [COMMAND_W-1:0] CMD_LITERAL = 2'd0;
    localparam logic [COMMAND_W-1:0] CMD_MATCH   = 2'd1;
    localparam logic [COMMAND_W-1:0] CMD_RESTART = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FILL_BYTE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FILL_POSITION  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ALLOW_OVERFLOW = 2'd2;

    // Configuration reset values
    localparam logic [BYTE_W-1:0]     FILL_BYTE_RESET      = 8'd32;
    localparam logic [FILL_POS_W-1:0] FILL_POSITION_RESET  = 12'd0;
    localparam logic                  ALLOW_OVERFLOW_RESET = 1'b1;

    typedef struct packed {
        logic [COMMAND_W-1:0] command;
        logic [BYTE_W-1:0]    literal_byte;
        logic [OFFSET_W-1:0]  match_offset;
        logic [LENCODE_W-1:0] length_code;
    } token_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_token;
    } result_t;

endpackage

`default_nettype wire

FILE: design/lzwd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/lzss_window_decoder.sv
// LZSS token decoder over a circular history window held in block RAM.
//
// Tokens arrive on the token channel (token_valid / token_stall) and decoded
// bytes leave on the result channel (result_valid / result_stall), one byte
// per transfer, with last_of_token set on the final byte of each token.
// One token is worked on at a time; token_stall is low only while idle.
// A literal passes through ST_LIT, which loads its byte into the output
// register once that is free and then returns to idle for the next token.
// A match of L = length_code + 3 bytes passes a setup state, then reads L bytes of the
// window through its single read port into a run buffer; then each byte goes
// through ST_EMIT_RD to read the run buffer and ST_EMIT_WR to write it back to
// the window while it loads the output register.
// A restart, and reset, run a clearing pass that writes the fill byte to each
// of the 2^WINDOW_BITS window entries (4096 by default); no token is taken
// during the pass, configuration writes are taken as ever.
// A stalled result holds in the output register and the decoder waits with
// it; a new byte loads in the same cycle the held one transfers.
// Configuration is written through cfg_write / cfg_index / cfg_data.
`default_nettype none

module lzss_window_decoder #(
    parameter int WINDOW_BITS = lzwd_pkg::WINDOW_BITS_DEFAULT,
    parameter int LENGTH_BITS = lzwd_pkg::LENGTH_BITS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              token_valid,
    output logic                                   token_stall,
    input  wire lzwd_pkg::token_t                  token,
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output lzwd_pkg::result_t                      result,
    input  wire logic                              cfg_write,
    input  wire logic [lzwd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [lzwd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int W      = WINDOW_BITS;
    localparam int LB     = LENGTH_BITS;
    localparam int LEN_W  = LB + 1;
    localparam int SUM_W  = ((W > LEN_W) ? W : LEN_W) + 1;
    localparam int BYTE_W = lzwd_pkg::BYTE_W;

    localparam logic [2:0] ST_SWEEP   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_LIT     = 3'd2;
    localparam logic [2:0] ST_MSETUP  = 3'd3;
    localparam logic [2:0] ST_READ    = 3'd4;
    localparam logic [2:0] ST_EMIT_RD = 3'd5;
    localparam logic [2:0] ST_EMIT_WR = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [W-1:0]      wp_reg, wp_next;
    logic [W-1:0]      oldest_reg, oldest_next;
    logic              filling_reg, filling_next;
    logic [BYTE_W-1:0] fill_byte_reg, fill_byte_next;
    logic [lzwd_pkg::FILL_POS_W-1:0] fill_pos_reg, fill_pos_next;
    logic              allow_reg, allow_next;
    logic [BYTE_W-1:0] sweep_byte_reg, sweep_byte_next;
    logic [W-1:0]      sweep_cnt_reg, sweep_cnt_next;
    logic [BYTE_W-1:0] lit_reg, lit_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [W-1:0]      start_reg, start_next;
    logic              repeat_reg, repeat_next;
    logic [W-1:0]      pos_reg, pos_next;
    logic [LEN_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic              cap_valid_reg, cap_valid_next;
    logic [LEN_W-1:0]  cap_idx_reg, cap_idx_next;
    logic [LEN_W-1:0]  emit_idx_reg, emit_idx_next;
    logic              out_valid_reg, out_valid_next;
    lzwd_pkg::result_t out_data_reg, out_data_next;

    logic              hist_we, hist_re;
    logic [W-1:0]      hist_waddr;
    logic [BYTE_W-1:0] hist_wdata, hist_rdata;
    logic              buf_re;
    logic [BYTE_W-1:0] buf_rdata;

    logic              accept;
    logic              out_free;
    logic              store;
    logic [BYTE_W-1:0] store_byte;
    logic [W-1:0]      wp_inc;
    logic              filling_after;

    lzwd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (2 ** W)
    ) u_history (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .re    (hist_re),
        .raddr (pos_reg),
        .rdata (hist_rdata)
    );

    lzwd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (2 ** LEN_W)
    ) u_run_buf (
        .clk   (clk),
        .we    (cap_valid_reg),
        .waddr (cap_idx_reg),
        .wdata (hist_rdata),
        .re    (buf_re),
        .raddr (emit_idx_reg),
        .rdata (buf_rdata)
    );

    assign token_stall  = (state_reg != ST_IDLE);
    assign accept       = token_valid && !token_stall;
    assign out_free     = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // Window advance for one stored byte
    assign wp_inc        = wp_reg + W'(1);
    assign filling_after = filling_reg && (wp_inc != oldest_reg);

    always_comb
    begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        oldest_next     = oldest_reg;
        filling_next    = filling_reg;
        fill_byte_next  = fill_byte_reg;
        fill_pos_next   = fill_pos_reg;
        allow_next      = allow_reg;
        sweep_byte_next = sweep_byte_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        lit_next        = lit_reg;
        len_next        = len_reg;
        start_next      = start_reg;
        repeat_next     = repeat_reg;
        pos_next        = pos_reg;
        rd_cnt_next     = rd_cnt_reg;
        cap_valid_next  = 1'b0;
        cap_idx_next    = cap_idx_reg;
        emit_idx_next   = emit_idx_reg;
        out_valid_next  = out_valid_reg && result_stall;
        out_data_next   = out_data_reg;
        hist_we         = 1'b0;
        hist_waddr      = wp_reg;
        hist_wdata      = sweep_byte_reg;
        hist_re         = 1'b0;
        buf_re          = 1'b0;
        store           = 1'b0;
        store_byte      = lit_reg;

        if (cfg_write)
        begin
            unique case (cfg_index)
                lzwd_pkg::REG_FILL_BYTE:      fill_byte_next = cfg_data[BYTE_W-1:0];
                lzwd_pkg::REG_FILL_POSITION:  fill_pos_next  = cfg_data;
                lzwd_pkg::REG_ALLOW_OVERFLOW: allow_next     = cfg_data[0];
                default:                      ;
            endcase
        end

        unique case (state_reg)
            ST_SWEEP:
            begin
                hist_we        = 1'b1;
                hist_waddr     = sweep_cnt_reg;
                hist_wdata     = sweep_byte_reg;
                sweep_cnt_next = sweep_cnt_reg + W'(1);
                if (sweep_cnt_reg == {W{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    lit_next   = token.literal_byte;
                    len_next   = LEN_W'(LB'(token.length_code)) + LEN_W'(lzwd_pkg::MIN_MATCH);
                    start_next = oldest_reg + W'(token.match_offset);
                    unique case (token.command)
                        lzwd_pkg::CMD_LITERAL: state_next = ST_LIT;
                        lzwd_pkg::CMD_MATCH:   state_next = ST_MSETUP;
                        lzwd_pkg::CMD_RESTART:
                        begin
                            state_next      = ST_SWEEP;
                            sweep_cnt_next  = '0;
                            sweep_byte_next = fill_byte_reg;
                            oldest_next     = '0;
                            wp_next         = W'(fill_pos_reg);
                            filling_next    = 1'b1;
                        end
                        default:               state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LIT:
            begin
                if (out_free)
                begin
                    store          = 1'b1;
                    store_byte     = lit_reg;
                    out_valid_next = 1'b1;
                    out_data_next  = '{out_byte: lit_reg, last_of_token: 1'b1};
                    state_next     = ST_IDLE;
                end
            end
            ST_MSETUP:
            begin
                // Window not yet full, no overrun allowed and the copy runs past the write point: repeat the start byte
                repeat_next = filling_reg && !allow_reg &&
                              ((SUM_W'(start_reg) + SUM_W'(len_reg)) > SUM_W'(wp_reg));
                pos_next    = start_reg;
                rd_cnt_next = '0;
                state_next  = ST_READ;
            end
            ST_READ:
            begin
                hist_re        = 1'b1;
                cap_valid_next = 1'b1;
                cap_idx_next   = rd_cnt_reg;
                rd_cnt_next    = rd_cnt_reg + LEN_W'(1);
                if (!repeat_reg)
                begin
                    pos_next = pos_reg + W'(1);
                end
                if (rd_cnt_reg == len_reg - LEN_W'(1))
                begin
                    emit_idx_next = '0;
                    state_next    = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                buf_re     = 1'b1;
                state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR:
            begin
                if (out_free)
                begin
                    store          = 1'b1;
                    store_byte     = buf_rdata;
                    out_valid_next = 1'b1;
                    out_data_next  = '{out_byte: buf_rdata,
                                       last_of_token: (emit_idx_reg == len_reg - LEN_W'(1))};
                    if (emit_idx_reg == len_reg - LEN_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + LEN_W'(1);
                        state_next    = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Write the byte back at the write point and advance the window
        if (store)
        begin
            hist_we      = 1'b1;
            hist_waddr   = wp_reg;
            hist_wdata   = store_byte;
            wp_next      = wp_inc;
            filling_next = filling_after;
            if (!filling_after)
            begin
                oldest_next = oldest_reg + W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            wp_reg         <= W'(lzwd_pkg::FILL_POSITION_RESET);
            oldest_reg     <= '0;
            filling_reg    <= 1'b1;
            fill_byte_reg  <= lzwd_pkg::FILL_BYTE_RESET;
            fill_pos_reg   <= lzwd_pkg::FILL_POSITION_RESET;
            allow_reg      <= lzwd_pkg::ALLOW_OVERFLOW_RESET;
            sweep_byte_reg <= lzwd_pkg::FILL_BYTE_RESET;
            sweep_cnt_reg  <= '0;
            rd_cnt_reg     <= '0;
            cap_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            oldest_reg     <= oldest_next;
            filling_reg    <= filling_next;
            fill_byte_reg  <= fill_byte_next;
            fill_pos_reg   <= fill_pos_next;
            allow_reg      <= allow_next;
            sweep_byte_reg <= sweep_byte_next;
            sweep_cnt_reg  <= sweep_cnt_next;
            rd_cnt_reg     <= rd_cnt_next;
            cap_valid_reg  <= cap_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lit_reg      <= lit_next;
        len_reg      <= len_next;
        start_reg    <= start_next;
        repeat_reg   <= repeat_next;
        pos_reg      <= pos_next;
        cap_idx_reg  <= cap_idx_next;
        emit_idx_reg <= emit_idx_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for the LZSS window decoder: token stimulus, window predictor, checks.
`timescale 1ns / 1ps

module tb_top;
    import lzwd_pkg::*;

    localparam int                  WIN_BITS        = WINDOW_BITS_DEFAULT;
    localparam int                  QUIET_CYCLES    = (1 << WIN_BITS) + 64;
    localparam int                  DRAIN_LIMIT     = 200000;
    localparam int                  HOLD_CYCLES     = 400;
    localparam int                  ITEMS_PER_PHASE = 30;
    localparam int                  MAX_RUN         = (1 << LENCODE_W) - 1 + MIN_MATCH;
    localparam logic [COMMAND_W-1:0]   CMD_UNUSED   = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED   = 2'd3;

    // Window predictor and queue of bytes the decoder still owes.
    class decode_scoreboard;
        localparam int WIN_SIZE = 1 << WIN_BITS;

        logic [BYTE_W-1:0]     window_mem [WIN_SIZE];
        logic [WIN_BITS-1:0]   oldest_ptr;
        logic [WIN_BITS-1:0]   write_ptr;
        bit                    filling;
        logic [BYTE_W-1:0]     fill_value;
        logic [FILL_POS_W-1:0] fill_start;
        bit                    overflow_ok;
        result_t               owed_bytes [$];
        int                    mismatches;
        int                    bytes_checked;
        int                    literals;
        int                    match_count;
        int                    repeat_runs;
        int                    restarts;
        int                    ignored;

        function void power_on();
            fill_value  = FILL_BYTE_RESET;
            fill_start  = FILL_POSITION_RESET;
            overflow_ok = ALLOW_OVERFLOW_RESET;
            refill();
        endfunction

        function void refill();
            foreach (window_mem[i])
                window_mem[i] = fill_value;
            oldest_ptr = '0;
            write_ptr  = fill_start[WIN_BITS-1:0];
            filling    = 1'b1;
        endfunction

        function void store(input logic [BYTE_W-1:0] b);
            window_mem[write_ptr] = b;
            write_ptr = write_ptr + 1'b1;
            if (write_ptr == oldest_ptr)
                filling = 1'b0;
            if (!filling)
                oldest_ptr = oldest_ptr + 1'b1;
        endfunction

        function void write_register(input logic [CFG_INDEX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_FILL_BYTE:      fill_value  = data[BYTE_W-1:0];
                REG_FILL_POSITION:  fill_start  = data[FILL_POS_W-1:0];
                REG_ALLOW_OVERFLOW: overflow_ok = data[0];
                default: ;
            endcase
        endfunction

        function void note_token(input token_t t);
            logic [BYTE_W-1:0]   run_bytes [MAX_RUN];
            logic [WIN_BITS-1:0] start;
            logic [WIN_BITS-1:0] pos;
            int                  len;
            bit                  repeat_one;
            result_t             r;

            case (t.command)
                CMD_LITERAL:
                begin
                    r.out_byte      = t.literal_byte;
                    r.last_of_token = 1'b1;
                    owed_bytes.insert(owed_bytes.size(), r);
                    store(t.literal_byte);
                    literals++;
                end
                CMD_RESTART:
                begin
                    refill();
                    restarts++;
                end
                CMD_MATCH:
                begin
                    len   = int'(t.length_code) + MIN_MATCH;
                    start = oldest_ptr + t.match_offset[WIN_BITS-1:0];
                    // While filling without overflow, a copy past the write point
                    // degenerates to one byte repeated.
                    repeat_one = filling && !overflow_ok &&
                                 (int'(start) + len > int'(write_ptr));
                    pos = start;
                    for (int i = 0; i < len; i++)
                    begin
                        run_bytes[i] = window_mem[pos];
                        if (!repeat_one)
                            pos = pos + 1'b1;
                    end
                    for (int i = 0; i < len; i++)
                    begin
                        r.out_byte      = run_bytes[i];
                        r.last_of_token = (i == len - 1);
                        owed_bytes.insert(owed_bytes.size(), r);
                    end
                    for (int i = 0; i < len; i++)
                        store(run_bytes[i]);
                    match_count++;
                    if (repeat_one)
                        repeat_runs++;
                end
                default: ignored++;
            endcase
        endfunction

        task report_mismatch(input string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(input result_t got);
            result_t want;

            if (owed_bytes.size() == 0)
            begin
                report_mismatch($sformatf("byte %02h with nothing expected", got.out_byte));
                return;
            end
            want = owed_bytes.pop_front();
            bytes_checked++;
            if (got.out_byte !== want.out_byte)
                report_mismatch($sformatf("out_byte %02h, want %02h",
                                          got.out_byte, want.out_byte));
            if (got.last_of_token !== want.last_of_token)
                report_mismatch($sformatf("last_of_token %0b, want %0b (byte %02h)",
                                          got.last_of_token, want.last_of_token,
                                          want.out_byte));
        endtask

        function int pending();
            return owed_bytes.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   token_valid;
    logic                   token_stall;
    token_t                 token;
    logic                   result_valid;
    logic                   result_stall;
    result_t                result;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    decode_scoreboard sb;
    int               send_gap_pct;
    int               stall_pct;
    int               hold_requests;
    int               phases;

    lzss_window_decoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .token_valid  (token_valid),
        .token_stall  (token_stall),
        .token        (token),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("timeout with %0d bytes outstanding", sb.pending());
        $display("simulation failed");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        int hold_left;
        int served;

        hold_left    = 0;
        served       = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (served != hold_requests)
            begin
                served    = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else
                result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
    end

    function automatic token_t make_token(input logic [COMMAND_W-1:0] cmd,
                                          input logic [BYTE_W-1:0] lit,
                                          input logic [OFFSET_W-1:0] offset,
                                          input logic [LENCODE_W-1:0] len_code);
        token_t t;

        t.command      = cmd;
        t.literal_byte = lit;
        t.match_offset = offset;
        t.length_code  = len_code;
        return t;
    endfunction

    // About half are copies, mostly from recent history, so overlaps and the write point get hit.
    function automatic token_t random_token();
        token_t              t;
        int                  pick;
        logic [WIN_BITS-1:0] back;

        t.literal_byte = BYTE_W'($urandom_range(255));
        t.match_offset = OFFSET_W'($urandom_range(4095));
        t.length_code  = LENCODE_W'($urandom_range(15));
        pick = $urandom_range(99);
        if (pick < 3)
            t.command = CMD_RESTART;
        else if (pick < 5)
            t.command = CMD_UNUSED;
        else if (pick < 50)
            t.command = CMD_LITERAL;
        else
        begin
            t.command = CMD_MATCH;
            if ($urandom_range(99) < 65)
            begin
                back = WIN_BITS'($urandom_range(40, 1));
                t.match_offset = sb.write_ptr - sb.oldest_ptr - back;
            end
        end
        return t;
    endfunction

    task automatic send_token(input token_t item);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            token_valid <= 1'b0;
            @(negedge clk);
        end
        token_valid <= 1'b1;
        token       <= item;
        do
            @(posedge clk);
        while (token_stall);
        sb.note_token(item);
    endtask

    task automatic release_token();
        @(negedge clk);
        token_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        int guard;

        guard = 0;
        while (sb.pending() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_register(idx, data);
    endtask

    // Drain, let any clearing pass finish, reprogram, then restart onto the new fill.
    task automatic start_phase(input logic [BYTE_W-1:0] fill,
                               input logic [FILL_POS_W-1:0] pos,
                               input bit ovf, input int gap, input int stall,
                               input bit poke_unused);
        release_token();
        wait_drained();
        repeat (QUIET_CYCLES) @(negedge clk);
        write_register(REG_FILL_BYTE, CFG_DATA_W'(fill));
        write_register(REG_FILL_POSITION, CFG_DATA_W'(pos));
        write_register(REG_ALLOW_OVERFLOW, CFG_DATA_W'(ovf));
        if (poke_unused)
            write_register(REG_UNUSED, '1);
        @(negedge clk);
        cfg_write    <= 1'b0;
        send_gap_pct  = gap;
        stall_pct     = stall;
        phases++;
        send_token(make_token(CMD_RESTART, BYTE_W'($urandom_range(255)),
                              OFFSET_W'($urandom_range(4095)),
                              LENCODE_W'($urandom_range(15))));
    endtask

    initial
    begin
        token_t item;
        int     issued;

        rst_n         = 1'b0;
        token_valid   = 1'b0;
        token         = '0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        send_gap_pct  = 0;
        stall_pct     = 0;
        hold_requests = 0;
        phases        = 1;
        sb = new();
        sb.power_on();
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: literals, copies across the write point and the wrap, odd tokens, a restart.
        send_token(make_token(CMD_LITERAL, 8'h00, 12'hFFF, 4'hF));
        send_token(make_token(CMD_LITERAL, 8'hFF, 12'h000, 4'h0));
        send_token(make_token(CMD_LITERAL, 8'h5A, 12'hABC, 4'h5));
        send_token(make_token(CMD_MATCH, 8'h00, 12'd0, 4'd0));
        send_token(make_token(CMD_MATCH, 8'h00, 12'd1, 4'd15));
        send_token(make_token(CMD_MATCH, 8'hFF, 12'hFFF, 4'd15));
        send_token(make_token(CMD_UNUSED, 8'hFF, 12'hFFF, 4'hF));
        send_token(make_token(CMD_MATCH, 8'h3C, 12'd2, 4'd7));
        send_token(make_token(CMD_RESTART, 8'hFF, 12'hFFF, 4'hF));
        send_token(make_token(CMD_LITERAL, 8'h81, 12'd0, 4'd0));
        send_token(make_token(CMD_MATCH, 8'h00, 12'hFFE, 4'd3));

        for (int p = 1; p <= 8; p++)
        begin
            case (p)
                1: start_phase(8'hC3, 12'd5, 1'b0, 0, 0, 1'b1);
                2: start_phase(8'hFF, 12'd4095, 1'b1, 79, 0, 1'b0);
                3: start_phase(8'h00, 12'd4000, 1'b0, 0, 79, 1'b0);
                4: start_phase(8'hA5, 12'd2048, 1'b1, 10, 10, 1'b0);
                5: start_phase(BYTE_W'($urandom_range(255)), 12'd4060, 1'b0, 0, 0, 1'b0);
                6: start_phase(BYTE_W'($urandom_range(255)), FILL_POS_W'($urandom_range(4095)),
                               1'b1, 79, 0, 1'b0);
                7: start_phase(8'h5A, 12'd4090, 1'b0, 0, 79, 1'b0);
                default: start_phase(BYTE_W'($urandom_range(255)), 12'd0, 1'b1, 10, 10, 1'b0);
            endcase

            if (p == 1)
            begin
                // No overflow while filling: a normal copy, single-byte repeats, then another normal copy.
                send_token(make_token(CMD_LITERAL, 8'h11, 12'd0, 4'd0));
                send_token(make_token(CMD_LITERAL, 8'h22, 12'd0, 4'd0));
                send_token(make_token(CMD_LITERAL, 8'h33, 12'd0, 4'd0));
                send_token(make_token(CMD_MATCH, 8'h00, 12'd5, 4'd0));
                send_token(make_token(CMD_MATCH, 8'h00, 12'd6, 4'd15));
                send_token(make_token(CMD_MATCH, 8'h00, 12'hFFF, 4'd15));
                send_token(make_token(CMD_MATCH, 8'h00, 12'd0, 4'd0));
                send_token(make_token(CMD_LITERAL, 8'hE7, 12'd0, 4'd0));
            end

            // Hold off the receiver while tokens keep coming, so the decoder backs up.
            if (p == 5)
                hold_requests++;

            issued = 0;
            while (issued < ITEMS_PER_PHASE)
            begin
                item = random_token();
                send_token(item);
                if (item.command != CMD_UNUSED)
                begin
                    issued++;
                    if (p == 4 && issued == ITEMS_PER_PHASE / 2)
                    begin
                        release_token();
                        wait_drained();
                    end
                end
            end
        end

        release_token();
        wait_drained();
        repeat (QUIET_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d expected bytes never arrived", sb.pending()));

        $display("covered %0d literals, %0d matches (%0d single-byte repeats), %0d restarts,",
                 sb.literals, sb.match_count, sb.repeat_runs, sb.restarts);
        $display("%0d ignored tokens; %0d bytes checked over %0d setting phases, %0d mismatches",
                 sb.ignored, sb.bytes_checked, phases, sb.mismatches);
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
